[hw/rtl/fts_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and timing constants for the fan timer speed controller
// no dependencies; used by the interfaces and every module of the block
package fts_pkg;

  // timing
  localparam int PWM_PERIOD       = 1000;
  localparam int TICKS_PER_SECOND = 20;
  localparam int TICKS_MAX        = 16383;
  localparam int SECS_PER_MIN     = 60;
  localparam int TICKS_PER_MIN    = SECS_PER_MIN * TICKS_PER_SECOND;

  // field widths
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int TEMP_W  = 8;
  localparam int SPEED_W = 2;
  localparam int MIN_W   = 4;
  localparam int SEC_W   = 6;
  localparam int SETP_W  = 7;
  localparam int DIGIT_W = 4;
  localparam int DUTY_W  = 10;
  localparam int REG_W   = 3;

  // countdown held as minutes, seconds and sub-second ticks
  localparam int MINQ_MAX = TICKS_MAX / TICKS_PER_MIN;
  localparam int QW       = ($clog2(MINQ_MAX + 1) > MIN_W) ? $clog2(MINQ_MAX + 1) : MIN_W;
  localparam int SUB_W    = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam int SAT_Q    = TICKS_MAX / TICKS_PER_MIN;
  localparam int SAT_S    = (TICKS_MAX % TICKS_PER_MIN) / TICKS_PER_SECOND;
  localparam int SAT_R    = TICKS_MAX % TICKS_PER_SECOND;
  localparam int LOAD_W   = $clog2(63 * TICKS_PER_SECOND + 15 * TICKS_PER_MIN + 1);
  localparam int MIN_SHOWN_MAX = 15;

  // pwm counter holds up to the start count or the period
  localparam int PCW = ($clog2(PWM_PERIOD + 1) > DUTY_W) ? $clog2(PWM_PERIOD + 1) : DUTY_W;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // op codes
  localparam logic [OP_W-1:0] OP_CMD       = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd1;
  localparam logic [OP_W-1:0] OP_SPEED_BTN = 3'd2;
  localparam logic [OP_W-1:0] OP_STATE_BTN = 3'd3;
  localparam logic [OP_W-1:0] OP_TIMER_BTN = 3'd4;
  localparam logic [OP_W-1:0] OP_PWM       = 3'd5;

  // command bytes
  localparam logic [BYTE_W-1:0] CMD_STOP      = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_RUN       = 8'h31;
  localparam logic [BYTE_W-1:0] CMD_LOW       = 8'h32;
  localparam logic [BYTE_W-1:0] CMD_MID       = 8'h33;
  localparam logic [BYTE_W-1:0] CMD_HIGH      = 8'h34;
  localparam logic [BYTE_W-1:0] CMD_ARM_MIN   = 8'h35;
  localparam logic [BYTE_W-1:0] CMD_ARM_SEC   = 8'h36;
  localparam logic [BYTE_W-1:0] CMD_START     = 8'h37;
  localparam logic [BYTE_W-1:0] CMD_ARM_SETP  = 8'h38;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_NINE    = 8'h39;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX    = 4'd9;

  // reply bytes
  localparam logic [BYTE_W-1:0] TX_STOPPED    = 8'h30;
  localparam logic [BYTE_W-1:0] TX_RUNNING    = 8'h31;
  localparam logic [BYTE_W-1:0] TX_SPEED_BASE = 8'h32;
  localparam logic [BYTE_W-1:0] TX_TIMER      = 8'h37;

  // speeds
  localparam logic [SPEED_W-1:0] SPEED_LOW  = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_MID  = 2'd1;
  localparam logic [SPEED_W-1:0] SPEED_HIGH = 2'd2;

  // digit targets
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_MIN  = 2'd1;
  localparam logic [1:0] PEND_SEC  = 2'd2;
  localparam logic [1:0] PEND_SETP = 2'd3;

  // register indexes
  localparam logic [REG_W-1:0] REG_DUTY_LOW   = 3'd0;
  localparam logic [REG_W-1:0] REG_DUTY_MID   = 3'd1;
  localparam logic [REG_W-1:0] REG_DUTY_HIGH  = 3'd2;
  localparam logic [REG_W-1:0] REG_START_CNTS = 3'd3;

  // reset values
  localparam logic [DUTY_W-1:0] DUTY_LOW_RST   = 10'd300;
  localparam logic [DUTY_W-1:0] DUTY_MID_RST   = 10'd600;
  localparam logic [DUTY_W-1:0] DUTY_HIGH_RST  = 10'd900;
  localparam logic [DUTY_W-1:0] START_CNTS_RST = 10'd1000;
  localparam logic [MIN_W-1:0]  MINUTE_RST     = 4'd1;
  localparam logic [SEC_W-1:0]  SECOND_RST     = 6'd5;
  localparam logic [SETP_W-1:0] SETPOINT_RST   = 7'd26;

  typedef enum logic [2:0] {
    EV_CMD, EV_TICK, EV_SPEED_BTN, EV_STATE_BTN, EV_TIMER_BTN, EV_PWM, EV_NONE
  } ev_kind_t;

  typedef enum logic [2:0] {
    CK_STOP, CK_RUN, CK_SPEED, CK_ARM, CK_START, CK_OTHER
  } cmd_kind_t;

  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [BYTE_W-1:0]        rx_byte;
    logic signed [TEMP_W-1:0] measured_temp;
  } in_item_t;

  typedef struct packed {
    logic               motor_drive;
    logic               run_mode;
    logic [SPEED_W-1:0] fan_speed;
    logic [MIN_W-1:0]   minutes_shown;
    logic [SEC_W-1:0]   seconds_shown;
    logic               countdown_active;
    logic               tx_valid;
    logic [BYTE_W-1:0]  tx_byte;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0]  reg_index;
    logic [DUTY_W-1:0] wdata;
  } cfg_item_t;

  // classified event as it travels from front to back
  typedef struct packed {
    ev_kind_t                 ev;
    cmd_kind_t                cmd;
    logic [1:0]               sel;
    logic [DIGIT_W-1:0]       digit;
    logic [BYTE_W-1:0]        rx_byte;
    logic signed [TEMP_W-1:0] temp;
  } work_t;

endpackage

[hw/rtl/fts_if.sv]
`timescale 1ns / 1ps
// valid/ready channels of the fan timer speed controller: events, results, config
// depends on fts_pkg for the payload types
interface fts_event_if;
  logic             valid;
  logic             ready;
  fts_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_result_if;
  logic               valid;
  logic               ready;
  fts_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fts_cfg_if;
  logic               valid;
  logic               ready;
  fts_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/fts_front.sv]
`timescale 1ns / 1ps
// front end: takes event requests and classifies op and command byte
// depends on fts_pkg and fts_event_if
module fts_front (
  fts_event_if.sink       events,
  input  logic            q_ready,
  output logic            push,
  output fts_pkg::work_t  work
);

  assign events.ready = q_ready;
  assign push         = events.valid && q_ready;

  always_comb begin
    work         = '0;
    work.rx_byte = events.data.rx_byte;
    work.temp    = events.data.measured_temp;

    case (events.data.op)
      fts_pkg::OP_CMD:       work.ev = fts_pkg::EV_CMD;
      fts_pkg::OP_TICK:      work.ev = fts_pkg::EV_TICK;
      fts_pkg::OP_SPEED_BTN: work.ev = fts_pkg::EV_SPEED_BTN;
      fts_pkg::OP_STATE_BTN: work.ev = fts_pkg::EV_STATE_BTN;
      fts_pkg::OP_TIMER_BTN: work.ev = fts_pkg::EV_TIMER_BTN;
      fts_pkg::OP_PWM:       work.ev = fts_pkg::EV_PWM;
      default:               work.ev = fts_pkg::EV_NONE;
    endcase

    work.sel = fts_pkg::PEND_NONE;
    case (events.data.rx_byte)
      fts_pkg::CMD_STOP:     work.cmd = fts_pkg::CK_STOP;
      fts_pkg::CMD_RUN:      work.cmd = fts_pkg::CK_RUN;
      fts_pkg::CMD_LOW: begin
        work.cmd = fts_pkg::CK_SPEED;
        work.sel = fts_pkg::SPEED_LOW;
      end
      fts_pkg::CMD_MID: begin
        work.cmd = fts_pkg::CK_SPEED;
        work.sel = fts_pkg::SPEED_MID;
      end
      fts_pkg::CMD_HIGH: begin
        work.cmd = fts_pkg::CK_SPEED;
        work.sel = fts_pkg::SPEED_HIGH;
      end
      fts_pkg::CMD_ARM_MIN: begin
        work.cmd = fts_pkg::CK_ARM;
        work.sel = fts_pkg::PEND_MIN;
      end
      fts_pkg::CMD_ARM_SEC: begin
        work.cmd = fts_pkg::CK_ARM;
        work.sel = fts_pkg::PEND_SEC;
      end
      fts_pkg::CMD_ARM_SETP: begin
        work.cmd = fts_pkg::CK_ARM;
        work.sel = fts_pkg::PEND_SETP;
      end
      fts_pkg::CMD_START:    work.cmd = fts_pkg::CK_START;
      default:               work.cmd = fts_pkg::CK_OTHER;
    endcase

    // digit value clamped to 0..9
    if (events.data.rx_byte < fts_pkg::DIGIT_ZERO) begin
      work.digit = '0;
    end else if (events.data.rx_byte > fts_pkg::DIGIT_NINE) begin
      work.digit = fts_pkg::DIGIT_MAX;
    end else begin
      work.digit = fts_pkg::DIGIT_W'(events.data.rx_byte - fts_pkg::DIGIT_ZERO);
    end
  end

endmodule

[hw/rtl/fts_queue.sv]
`timescale 1ns / 1ps
// short fifo of classified events between the front and the back
// depends on fts_pkg
module fts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fts_pkg::work_t push_data,
  output logic           q_ready,
  input  logic           pop,
  output logic           q_valid,
  output fts_pkg::work_t head
);

  fts_pkg::work_t              entries [fts_pkg::QUEUE_DEPTH];
  logic [fts_pkg::QPTR_W-1:0]  wr_ptr;
  logic [fts_pkg::QPTR_W-1:0]  rd_ptr;
  logic [fts_pkg::QCNT_W-1:0]  count;

  function automatic logic [fts_pkg::QPTR_W-1:0] ptr_inc(
    input logic [fts_pkg::QPTR_W-1:0] p
  );
    if (p == fts_pkg::QPTR_W'(fts_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign q_ready = count < fts_pkg::QCNT_W'(fts_pkg::QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hw/rtl/fts_back.sv]
`timescale 1ns / 1ps
// back end: executes classified events on the controller state, holds the
// config registers and the result register; depends on fts_pkg and fts_if
module fts_back (
  input  logic             clk,
  input  logic             rst,
  fts_cfg_if.sink          cfg,
  input  logic             q_valid,
  input  fts_pkg::work_t   head,
  output logic             pop,
  fts_result_if.source     results
);

  // config registers
  logic [fts_pkg::DUTY_W-1:0] duty_low;
  logic [fts_pkg::DUTY_W-1:0] duty_mid;
  logic [fts_pkg::DUTY_W-1:0] duty_high;
  logic [fts_pkg::DUTY_W-1:0] start_counts;

  // controller state
  logic                        mode_running, mode_running_next;
  logic [fts_pkg::SPEED_W-1:0] speed_level, speed_level_next;
  logic [fts_pkg::MIN_W-1:0]   minute_count, minute_count_next;
  logic [fts_pkg::SEC_W-1:0]   second_count, second_count_next;
  logic [fts_pkg::SETP_W-1:0]  temp_setpoint, temp_setpoint_next;
  logic [fts_pkg::QW-1:0]      cd_min, cd_min_next;
  logic [fts_pkg::SEC_W-1:0]   cd_sec, cd_sec_next;
  logic [fts_pkg::SUB_W-1:0]   cd_sub, cd_sub_next;
  logic                        countdown_on, countdown_on_next;
  logic [1:0]                  pending_digit, pending_digit_next;
  logic [fts_pkg::PCW-1:0]     pwm_counter, pwm_counter_next;
  logic                        start_done, start_done_next;
  logic [fts_pkg::DUTY_W-1:0]  latched_duty, latched_duty_next;
  logic                        drive_level, drive_level_next;
  logic                        tx_valid_next;
  logic [fts_pkg::BYTE_W-1:0]  tx_byte_next;

  logic                        out_valid;
  fts_pkg::out_item_t          out_data;
  logic                        take;

  // countdown load, shared by the start command and the timer button
  logic [fts_pkg::LOAD_W-1:0]  load_ticks;
  logic                        load_sat;
  logic                        load_zero;

  assign load_ticks = fts_pkg::LOAD_W'(second_count) * fts_pkg::LOAD_W'(fts_pkg::TICKS_PER_SECOND)
                    + fts_pkg::LOAD_W'(minute_count) * fts_pkg::LOAD_W'(fts_pkg::TICKS_PER_MIN);
  assign load_sat   = load_ticks > fts_pkg::LOAD_W'(fts_pkg::TICKS_MAX);
  assign load_zero  = load_ticks == '0;

  assign take          = q_valid && (!out_valid || results.ready);
  assign pop           = take;
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_comb begin
    logic                        do_load;
    logic                        mode_set;
    logic                        mode_val;
    logic [fts_pkg::QW-1:0]      dm;
    logic [fts_pkg::SEC_W-1:0]   ds;
    logic [fts_pkg::SUB_W-1:0]   dr;
    logic signed [8:0]           diff;
    logic                        pwm_now;
    logic [fts_pkg::PCW-1:0]     pc;
    logic [fts_pkg::PCW:0]       pc_inc;
    logic [fts_pkg::DUTY_W-1:0]  duty_sel;
    logic [fts_pkg::SPEED_W-1:0] sp;

    mode_running_next  = mode_running;
    speed_level_next   = speed_level;
    minute_count_next  = minute_count;
    second_count_next  = second_count;
    temp_setpoint_next = temp_setpoint;
    cd_min_next        = cd_min;
    cd_sec_next        = cd_sec;
    cd_sub_next        = cd_sub;
    countdown_on_next  = countdown_on;
    pending_digit_next = pending_digit;
    pwm_counter_next   = pwm_counter;
    start_done_next    = start_done;
    latched_duty_next  = latched_duty;
    drive_level_next   = drive_level;
    tx_valid_next      = 1'b0;
    tx_byte_next       = '0;

    do_load  = 1'b0;
    mode_set = 1'b0;
    mode_val = 1'b0;
    dm       = cd_min;
    ds       = cd_sec;
    dr       = cd_sub;
    diff     = '0;
    pwm_now  = 1'b1;
    pc       = pwm_counter;
    pc_inc   = '0;
    duty_sel = latched_duty;
    sp       = speed_level;

    case (head.ev)
      fts_pkg::EV_CMD: begin
        tx_valid_next = 1'b1;
        tx_byte_next  = head.rx_byte;
        if (pending_digit != fts_pkg::PEND_NONE) begin
          case (pending_digit)
            fts_pkg::PEND_MIN: minute_count_next  = head.digit;
            fts_pkg::PEND_SEC: second_count_next  = fts_pkg::SEC_W'(head.digit);
            default:           temp_setpoint_next = fts_pkg::SETP_W'(head.digit);
          endcase
          pending_digit_next = fts_pkg::PEND_NONE;
        end else begin
          pending_digit_next = fts_pkg::PEND_NONE;
          case (head.cmd)
            fts_pkg::CK_STOP: begin
              mode_set = 1'b1;
              mode_val = 1'b0;
            end
            fts_pkg::CK_RUN: begin
              mode_set = 1'b1;
              mode_val = 1'b1;
            end
            fts_pkg::CK_SPEED: speed_level_next   = head.sel;
            fts_pkg::CK_ARM:   pending_digit_next = head.sel;
            fts_pkg::CK_START: do_load            = 1'b1;
            default: ;
          endcase
        end
      end

      fts_pkg::EV_TICK: begin
        if (countdown_on) begin
          // borrow through sub-ticks, seconds, minutes
          if (cd_sub != '0) begin
            dr = cd_sub - 1'b1;
          end else if (cd_sec != '0) begin
            ds = cd_sec - 1'b1;
            dr = fts_pkg::SUB_W'(fts_pkg::TICKS_PER_SECOND - 1);
          end else if (cd_min != '0) begin
            dm = cd_min - 1'b1;
            ds = fts_pkg::SEC_W'(fts_pkg::SECS_PER_MIN - 1);
            dr = fts_pkg::SUB_W'(fts_pkg::TICKS_PER_SECOND - 1);
          end
          cd_min_next = dm;
          cd_sec_next = ds;
          cd_sub_next = dr;
          if (dr == '0) begin
            diff = 9'(head.temp) - $signed({2'b00, temp_setpoint});
            second_count_next = ds;
            minute_count_next = (dm > fts_pkg::QW'(fts_pkg::MIN_SHOWN_MAX))
                              ? fts_pkg::MIN_W'(fts_pkg::MIN_SHOWN_MAX)
                              : fts_pkg::MIN_W'(dm);
            if (diff > 9'sd2) begin
              speed_level_next = fts_pkg::SPEED_HIGH;
            end else if (diff > 9'sd1) begin
              speed_level_next = fts_pkg::SPEED_MID;
            end else begin
              speed_level_next = fts_pkg::SPEED_LOW;
            end
          end
          if (dm == '0 && ds == '0 && dr == '0) begin
            mode_set          = 1'b1;
            mode_val          = 1'b0;
            countdown_on_next = 1'b0;
            tx_valid_next     = 1'b1;
            tx_byte_next      = fts_pkg::TX_STOPPED;
          end
        end
      end

      fts_pkg::EV_SPEED_BTN: begin
        if (mode_running) begin
          case (speed_level)
            fts_pkg::SPEED_LOW:  sp = fts_pkg::SPEED_MID;
            fts_pkg::SPEED_MID:  sp = fts_pkg::SPEED_HIGH;
            fts_pkg::SPEED_HIGH: sp = fts_pkg::SPEED_LOW;
            default:             sp = fts_pkg::SPEED_MID;
          endcase
          speed_level_next = sp;
          tx_valid_next    = 1'b1;
          tx_byte_next     = fts_pkg::TX_SPEED_BASE + fts_pkg::BYTE_W'(sp);
        end
      end

      fts_pkg::EV_STATE_BTN: begin
        mode_set      = 1'b1;
        mode_val      = !mode_running;
        tx_valid_next = 1'b1;
        tx_byte_next  = mode_running ? fts_pkg::TX_STOPPED : fts_pkg::TX_RUNNING;
      end

      fts_pkg::EV_TIMER_BTN: begin
        if (mode_running) begin
          do_load       = 1'b1;
          tx_valid_next = 1'b1;
          tx_byte_next  = fts_pkg::TX_TIMER;
        end
      end

      fts_pkg::EV_PWM: begin
        if (!mode_running) begin
          drive_level_next = 1'b0;
        end else begin
          // full-on start phase first
          if (!start_done) begin
            if (pc < fts_pkg::PCW'(start_counts)) begin
              drive_level_next = 1'b1;
              pc_inc = {1'b0, pc} + 1'b1;
              if (pc_inc >= (fts_pkg::PCW + 1)'(start_counts)) begin
                start_done_next = 1'b1;
                pc = '0;
              end else begin
                pc = pc_inc[fts_pkg::PCW-1:0];
              end
              pwm_now = 1'b0;
            end else begin
              start_done_next = 1'b1;
              pc = '0;
            end
          end
          if (pwm_now) begin
            if (pc == '0) begin
              case (speed_level)
                fts_pkg::SPEED_LOW: duty_sel = duty_low;
                fts_pkg::SPEED_MID: duty_sel = duty_mid;
                default:            duty_sel = duty_high;
              endcase
            end
            latched_duty_next = duty_sel;
            drive_level_next  = pc < fts_pkg::PCW'(duty_sel);
            pc_inc = {1'b0, pc} + 1'b1;
            if (pc_inc >= (fts_pkg::PCW + 1)'(fts_pkg::PWM_PERIOD)) begin
              pc = '0;
            end else begin
              pc = pc_inc[fts_pkg::PCW-1:0];
            end
          end
          pwm_counter_next = pc;
        end
      end

      default: ;
    endcase

    if (do_load) begin
      if (load_sat) begin
        cd_min_next = fts_pkg::QW'(fts_pkg::SAT_Q);
        cd_sec_next = fts_pkg::SEC_W'(fts_pkg::SAT_S);
        cd_sub_next = fts_pkg::SUB_W'(fts_pkg::SAT_R);
      end else begin
        cd_min_next = fts_pkg::QW'(minute_count);
        cd_sec_next = second_count;
        cd_sub_next = '0;
      end
      if (load_zero) begin
        countdown_on_next = 1'b0;
        mode_set          = 1'b1;
        mode_val          = 1'b0;
      end else begin
        countdown_on_next = 1'b1;
      end
    end

    // a change of run mode restarts the start phase
    if (mode_set && (mode_val != mode_running)) begin
      mode_running_next = mode_val;
      start_done_next   = 1'b0;
      pwm_counter_next  = '0;
      if (!mode_val) begin
        drive_level_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_low     <= fts_pkg::DUTY_LOW_RST;
      duty_mid     <= fts_pkg::DUTY_MID_RST;
      duty_high    <= fts_pkg::DUTY_HIGH_RST;
      start_counts <= fts_pkg::START_CNTS_RST;
    end else if (cfg.valid) begin
      case (cfg.data.reg_index)
        fts_pkg::REG_DUTY_LOW:   duty_low     <= cfg.data.wdata;
        fts_pkg::REG_DUTY_MID:   duty_mid     <= cfg.data.wdata;
        fts_pkg::REG_DUTY_HIGH:  duty_high    <= cfg.data.wdata;
        fts_pkg::REG_START_CNTS: start_counts <= cfg.data.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_running  <= 1'b0;
      speed_level   <= fts_pkg::SPEED_LOW;
      minute_count  <= fts_pkg::MINUTE_RST;
      second_count  <= fts_pkg::SECOND_RST;
      temp_setpoint <= fts_pkg::SETPOINT_RST;
      cd_min        <= '0;
      cd_sec        <= '0;
      cd_sub        <= '0;
      countdown_on  <= 1'b0;
      pending_digit <= fts_pkg::PEND_NONE;
      pwm_counter   <= '0;
      start_done    <= 1'b0;
      latched_duty  <= '0;
      drive_level   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (take) begin
        mode_running  <= mode_running_next;
        speed_level   <= speed_level_next;
        minute_count  <= minute_count_next;
        second_count  <= second_count_next;
        temp_setpoint <= temp_setpoint_next;
        cd_min        <= cd_min_next;
        cd_sec        <= cd_sec_next;
        cd_sub        <= cd_sub_next;
        countdown_on  <= countdown_on_next;
        pending_digit <= pending_digit_next;
        pwm_counter   <= pwm_counter_next;
        start_done    <= start_done_next;
        latched_duty  <= latched_duty_next;
        drive_level   <= drive_level_next;
        out_valid     <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data.motor_drive      <= drive_level_next;
      out_data.run_mode         <= mode_running_next;
      out_data.fan_speed        <= speed_level_next;
      out_data.minutes_shown    <= minute_count_next;
      out_data.seconds_shown    <= second_count_next;
      out_data.countdown_active <= countdown_on_next;
      out_data.tx_valid         <= tx_valid_next;
      out_data.tx_byte          <= tx_byte_next;
    end
  end

endmodule

[hw/rtl/fan_timer_speed_controller.sv]
`timescale 1ns / 1ps
// fan timer speed controller, top level
// depends on fts_pkg, fts_if, fts_front, fts_queue and fts_back
//
// events: one request per event (op, rx_byte, measured_temp): command byte,
//   timer tick, speed/state/timer button or pwm tick.
// results: exactly one request per event, in event order: motor drive level,
//   run mode, speed, shown minutes and seconds, countdown flag and an optional
//   reply byte (tx_byte is 0 when tx_valid is 0).
// cfg: register writes (duty low/mid/high, start counts), always ready;
//   write only while no event is in flight. Indexes beyond 3 are dropped.
// order: the queue entry is written at the accepting edge, and the result
//   register is written when the back end takes that entry from the queue.
// throughput: one event per cycle while the queue has room; the back end executes one queued event a
//   cycle whenever its result register is empty or being emptied.
// stall: when results.ready is low the result register holds, the back end
//   stops, and the two-entry queue takes up to two more events before
//   events.ready drops.
// reset: synchronous, active high; state returns to stopped, low speed,
//   1:05 on the timer, setpoint 26, config registers to their defaults.
module fan_timer_speed_controller (
  input  logic          clk,
  input  logic          rst,
  fts_event_if.sink     events,
  fts_result_if.source  results,
  fts_cfg_if.sink       cfg
);

  logic           push;
  logic           q_ready;
  logic           q_valid;
  logic           pop;
  fts_pkg::work_t work;
  fts_pkg::work_t head;

  fts_front u_front (
    .events  (events),
    .q_ready (q_ready),
    .push    (push),
    .work    (work)
  );

  fts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (work),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  fts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

  // no reply byte without a reply
  a_tx_quiet: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.data.tx_valid) |-> (results.data.tx_byte == '0))
    else $error("reply byte set without tx_valid");

  // a stopped fan is never driven
  a_stop_drive: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.data.run_mode) |-> !results.data.motor_drive)
    else $error("motor driven while stopped");

  // shown seconds stay a valid clock value
  a_seconds: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.data.seconds_shown < 6'(fts_pkg::SECS_PER_MIN)))
    else $error("seconds out of range");

  // an event reaches the back end only after it has been queued
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (!q_valid && !push) |=> !q_valid)
    else $error("queue shows an event that was never pushed");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// self-checking bench for fan_timer_speed_controller: directed events, then random
// mixes, countdown runs and long pwm stretches. depends on fts_pkg and fts_if
module tb_top;
  import fts_pkg::*;

  localparam logic [OP_W-1:0]  OP_SPARE_LO  = 3'd6;
  localparam logic [OP_W-1:0]  OP_SPARE_HI  = 3'd7;
  localparam logic [REG_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [REG_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int               QUIET_LIMIT  = 5000;
  localparam int               MAX_PRINTED  = 100;

  logic clk;
  logic rst;

  fts_event_if  ev_if ();
  fts_result_if res_if ();
  fts_cfg_if    cfg_if ();

  fan_timer_speed_controller uut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .results (res_if),
    .cfg     (cfg_if)
  );

  always #5 clk = ~clk;

  // predicted controller state
  logic                 st_running;
  logic [SPEED_W-1:0]   st_speed;
  logic [MIN_W-1:0]     st_minutes;
  logic [SEC_W-1:0]     st_seconds;
  logic [SETP_W-1:0]    st_setpoint;
  logic [13:0]          st_ticks;
  logic                 st_timer_on;
  logic [1:0]           st_arm;
  logic [10:0]          st_pwm_cnt;
  logic                 st_kick_done;
  logic [DUTY_W-1:0]    st_duty_held;
  logic                 st_drive;
  logic [DUTY_W-1:0]    duty_by_speed [3];
  logic [DUTY_W-1:0]    kick_len;

  out_item_t status_due [$];

  int mismatches      = 0;
  int events_sent     = 0;
  int results_seen    = 0;
  int settings_loaded = 0;
  int timer_expiries  = 0;
  int pwm_wraps       = 0;
  int quiet_cycles    = 0;
  int tx_burst        = 0;
  int rx_burst        = 0;
  int rx_wait         = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // idle cycles before the next request, with occasional stretches of none
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 9);
  endfunction

  function automatic void reset_fan_state();
    st_running    = 1'b0;
    st_speed      = SPEED_LOW;
    st_minutes    = MINUTE_RST;
    st_seconds    = SECOND_RST;
    st_setpoint   = SETPOINT_RST;
    st_ticks      = '0;
    st_timer_on   = 1'b0;
    st_arm        = PEND_NONE;
    st_pwm_cnt    = '0;
    st_kick_done  = 1'b0;
    st_duty_held  = '0;
    st_drive      = 1'b0;
    duty_by_speed[SPEED_LOW]  = DUTY_LOW_RST;
    duty_by_speed[SPEED_MID]  = DUTY_MID_RST;
    duty_by_speed[SPEED_HIGH] = DUTY_HIGH_RST;
    kick_len      = START_CNTS_RST;
  endfunction

  function automatic void change_mode(input logic run);
    if (run != st_running) begin
      st_running   = run;
      st_kick_done = 1'b0;
      st_pwm_cnt   = '0;
      if (!run) st_drive = 1'b0;
    end
  endfunction

  function automatic void load_timer();
    int t;
    t = int'(st_seconds) * TICKS_PER_SECOND + int'(st_minutes) * TICKS_PER_MIN;
    if (t > TICKS_MAX) t = TICKS_MAX;
    st_ticks = 14'(t);
    if (t == 0) begin
      st_timer_on = 1'b0;
      change_mode(1'b0);
    end else begin
      st_timer_on = 1'b1;
    end
  endfunction

  // status the block should report after one event
  function automatic out_item_t fan_response(input in_item_t it);
    out_item_t r;
    int        d;
    int        mq;
    int        diff;
    logic      pwm_now;
    r = '0;
    case (it.op)
      OP_CMD: begin
        if (st_arm != PEND_NONE) begin
          if (it.rx_byte < DIGIT_ZERO) d = 0;
          else if (it.rx_byte > DIGIT_NINE) d = int'(DIGIT_MAX);
          else d = int'(it.rx_byte - DIGIT_ZERO);
          case (st_arm)
            PEND_MIN: st_minutes = MIN_W'(d);
            PEND_SEC: st_seconds = SEC_W'(d);
            default:  st_setpoint = SETP_W'(d);
          endcase
          st_arm = PEND_NONE;
        end else begin
          case (it.rx_byte)
            CMD_STOP:     change_mode(1'b0);
            CMD_RUN:      change_mode(1'b1);
            CMD_LOW:      st_speed = SPEED_LOW;
            CMD_MID:      st_speed = SPEED_MID;
            CMD_HIGH:     st_speed = SPEED_HIGH;
            CMD_ARM_MIN:  st_arm = PEND_MIN;
            CMD_ARM_SEC:  st_arm = PEND_SEC;
            CMD_START:    load_timer();
            CMD_ARM_SETP: st_arm = PEND_SETP;
            default: ;
          endcase
        end
        r.tx_valid = 1'b1;
        r.tx_byte  = it.rx_byte;
      end
      OP_TICK: begin
        if (st_timer_on) begin
          if (st_ticks != 0) st_ticks = st_ticks - 14'd1;
          if (st_ticks % TICKS_PER_SECOND == 0) begin
            mq         = int'(st_ticks) / TICKS_PER_MIN;
            diff       = int'($signed(it.measured_temp)) - int'(st_setpoint);
            st_seconds = SEC_W'((int'(st_ticks) - mq * TICKS_PER_MIN) / TICKS_PER_SECOND);
            st_minutes = (mq > MIN_SHOWN_MAX) ? MIN_W'(MIN_SHOWN_MAX) : MIN_W'(mq);
            if (diff > 2) st_speed = SPEED_HIGH;
            else if (diff > 1) st_speed = SPEED_MID;
            else st_speed = SPEED_LOW;
          end
          if (st_ticks == 0) begin
            change_mode(1'b0);
            st_timer_on = 1'b0;
            timer_expiries++;
            r.tx_valid = 1'b1;
            r.tx_byte  = TX_STOPPED;
          end
        end
      end
      OP_SPEED_BTN: begin
        if (st_running) begin
          st_speed   = (st_speed == SPEED_HIGH) ? SPEED_LOW : st_speed + 2'd1;
          r.tx_valid = 1'b1;
          r.tx_byte  = TX_SPEED_BASE + BYTE_W'(st_speed);
        end
      end
      OP_STATE_BTN: begin
        change_mode(!st_running);
        r.tx_valid = 1'b1;
        r.tx_byte  = st_running ? TX_RUNNING : TX_STOPPED;
      end
      OP_TIMER_BTN: begin
        if (st_running) begin
          load_timer();
          r.tx_valid = 1'b1;
          r.tx_byte  = TX_TIMER;
        end
      end
      OP_PWM: begin
        if (!st_running) begin
          st_drive = 1'b0;
        end else begin
          pwm_now = 1'b1;
          // full-on kick after entering run
          if (!st_kick_done) begin
            if (st_pwm_cnt < kick_len) begin
              st_drive   = 1'b1;
              st_pwm_cnt = st_pwm_cnt + 11'd1;
              if (st_pwm_cnt >= kick_len) begin
                st_kick_done = 1'b1;
                st_pwm_cnt   = '0;
              end
              pwm_now = 1'b0;
            end else begin
              st_kick_done = 1'b1;
              st_pwm_cnt   = '0;
            end
          end
          if (pwm_now) begin
            // duty only taken at the start of a period
            if (st_pwm_cnt == 0) st_duty_held = duty_by_speed[st_speed];
            st_drive   = (st_pwm_cnt < st_duty_held);
            st_pwm_cnt = st_pwm_cnt + 11'd1;
            if (st_pwm_cnt >= PWM_PERIOD) begin
              st_pwm_cnt = '0;
              pwm_wraps++;
            end
          end
        end
      end
      default: ;
    endcase
    r.motor_drive      = st_drive;
    r.run_mode         = st_running;
    r.fan_speed        = st_speed;
    r.minutes_shown    = st_minutes;
    r.seconds_shown    = st_seconds;
    r.countdown_active = st_timer_on;
    return r;
  endfunction

  // valid is left high after each request and drops only when a gap before the next one is drawn
  task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] rx,
                            input int temp);
    in_item_t it;
    int       gap;
    it.op            = op;
    it.rx_byte       = rx;
    it.measured_temp = temp[TEMP_W-1:0];
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid <= 1'b1;
    ev_if.data  <= it;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    status_due.push_back(fan_response(it));
    events_sent++;
  endtask

  function automatic int any_temp();
    return int'($urandom_range(0, 165)) - 40;
  endfunction

  task automatic settle_block();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // four register writes plus one to an unused index, valid held across them
  task automatic apply_settings(input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] mid,
                                input logic [DUTY_W-1:0] hi, input logic [DUTY_W-1:0] kick);
    cfg_item_t writes [5];
    writes[0] = {REG_DUTY_LOW, lo};
    writes[1] = {REG_DUTY_MID, mid};
    writes[2] = {REG_SPARE_LO + REG_W'($urandom_range(0, REG_SPARE_HI - REG_SPARE_LO)),
                 DUTY_W'($urandom_range(0, 1023))};
    writes[3] = {REG_DUTY_HIGH, hi};
    writes[4] = {REG_START_CNTS, kick};
    foreach (writes[i]) begin
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= writes[i];
      @(posedge clk);
      while (!cfg_if.ready) @(posedge clk);
      case (writes[i].reg_index)
        REG_DUTY_LOW:   duty_by_speed[SPEED_LOW]  = writes[i].wdata;
        REG_DUTY_MID:   duty_by_speed[SPEED_MID]  = writes[i].wdata;
        REG_DUTY_HIGH:  duty_by_speed[SPEED_HIGH] = writes[i].wdata;
        REG_START_CNTS: kick_len = writes[i].wdata;
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic test_idle_and_commands();
    apply_settings(10'd0, 10'd1000, 10'd450, 10'd1);
    // while stopped: no drive, buttons ignored, ticks ignored
    send_event(OP_PWM, 8'h00, 0);
    send_event(OP_SPEED_BTN, 8'h00, 0);
    send_event(OP_TIMER_BTN, 8'h00, 0);
    send_event(OP_TICK, 8'h00, -40);
    send_event(OP_SPARE_LO, 8'h7E, 125);
    send_event(OP_SPARE_HI, 8'hFF, -1);
    send_event(OP_CMD, CMD_RUN, 0);
    send_event(OP_PWM, 8'h00, 0);
    send_event(OP_PWM, 8'h00, 0);
    send_event(OP_SPEED_BTN, 8'h00, 0);
    send_event(OP_CMD, CMD_HIGH, 0);
    send_event(OP_CMD, CMD_LOW, 0);
    send_event(OP_CMD, CMD_MID, 0);
    // digit bytes outside 0..9 clamp
    send_event(OP_CMD, CMD_ARM_MIN, 0);
    send_event(OP_CMD, 8'h00, 0);
    send_event(OP_CMD, CMD_ARM_SEC, 0);
    send_event(OP_CMD, 8'hFF, 0);
    send_event(OP_CMD, CMD_ARM_SETP, 0);
    send_event(OP_CMD, DIGIT_NINE, 0);
    send_event(OP_TIMER_BTN, 8'h00, 0);
    send_event(OP_TICK, 8'h00, 125);
    // zero-length load stops the fan
    send_event(OP_CMD, CMD_ARM_SEC, 0);
    send_event(OP_CMD, DIGIT_ZERO, 0);
    send_event(OP_CMD, CMD_START, 0);
    send_event(OP_STATE_BTN, 8'h00, 0);
    send_event(OP_STATE_BTN, 8'h00, 0);
    settle_block();
  endtask

  task automatic test_mixed_events(input int count);
    int               r;
    logic [OP_W-1:0]  op;
    logic [BYTE_W-1:0] rx;
    apply_settings(DUTY_W'($urandom_range(0, 1000)), DUTY_W'($urandom_range(0, 1000)),
                   DUTY_W'($urandom_range(0, 1000)), DUTY_W'($urandom_range(0, 30)));
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_CMD;
      else if (r < 55) op = OP_TICK;
      else if (r < 65) op = OP_SPEED_BTN;
      else if (r < 75) op = OP_STATE_BTN;
      else if (r < 80) op = OP_TIMER_BTN;
      else if (r < 97) op = OP_PWM;
      else op = OP_SPARE_LO + OP_W'($urandom_range(0, 1));
      if ($urandom_range(0, 3) != 0) rx = DIGIT_ZERO + BYTE_W'($urandom_range(0, 9));
      else rx = BYTE_W'($urandom_range(0, 255));
      send_event(op, rx, any_temp());
    end
    settle_block();
  endtask

  // set a short time, start it and tick it out, with some noise and broken runs
  task automatic test_countdowns(input int count);
    int first;
    int n;
    int temp;
    first = events_sent;
    apply_settings(DUTY_LOW_RST, DUTY_MID_RST, DUTY_HIGH_RST, 10'd1000);
    while (events_sent - first < count) begin
      send_event(OP_CMD, CMD_RUN, 0);
      if ($urandom_range(0, 2) == 0) begin
        send_event(OP_CMD, CMD_ARM_SETP, 0);
        send_event(OP_CMD, DIGIT_ZERO + BYTE_W'($urandom_range(0, 9)), 0);
      end
      send_event(OP_CMD, CMD_ARM_MIN, 0);
      send_event(OP_CMD, DIGIT_ZERO, 0);
      send_event(OP_CMD, CMD_ARM_SEC, 0);
      send_event(OP_CMD, DIGIT_ZERO + BYTE_W'($urandom_range(1, 2)), 0);
      if ($urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 1) == 0) send_event(OP_CMD, CMD_START, 0);
        else send_event(OP_TIMER_BTN, 8'h00, 0);
      end
      n = $urandom_range(15, 50);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          temp = int'(st_setpoint) + int'($urandom_range(0, 8)) - 3;
        else temp = any_temp();
        if ($urandom_range(0, 99) < 85) begin
          send_event(OP_TICK, 8'h00, temp);
        end else begin
          case ($urandom_range(0, 4))
            0: send_event(OP_PWM, 8'h00, temp);
            1: send_event(OP_SPEED_BTN, 8'h00, temp);
            2: send_event(OP_STATE_BTN, 8'h00, temp);
            3: send_event(OP_SPARE_LO + OP_W'($urandom_range(0, 1)), 8'h00, temp);
            default: send_event(OP_CMD, BYTE_W'($urandom_range(0, 255)), temp);
          endcase
        end
      end
    end
    settle_block();
  endtask

  // long run with no mode change so the pwm period wraps
  task automatic test_pwm_periods(input int count);
    int r;
    apply_settings(DUTY_W'($urandom_range(1, 999)), DUTY_W'($urandom_range(1, 999)),
                   10'd1000, 10'd0);
    // a zero-length load stops any countdown left running
    send_event(OP_CMD, CMD_ARM_MIN, 0);
    send_event(OP_CMD, DIGIT_ZERO, 0);
    send_event(OP_CMD, CMD_ARM_SEC, 0);
    send_event(OP_CMD, DIGIT_ZERO, 0);
    send_event(OP_CMD, CMD_START, 0);
    send_event(OP_CMD, CMD_RUN, 0);
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 96) send_event(OP_PWM, 8'h00, any_temp());
      else if (r < 99) send_event(OP_SPEED_BTN, 8'h00, any_temp());
      else send_event(OP_TICK, 8'h00, any_temp());
    end
    settle_block();
  endtask

  // result side: compare each accepted result, then draw the next stall
  always @(posedge clk) begin : status_check
    out_item_t want;
    if (res_if.valid && res_if.ready) begin
      results_seen++;
      if (status_due.size() == 0) begin
        report_mismatch("result with no event waiting");
      end else begin
        want = status_due.pop_front();
        check_field("motor_drive", res_if.data.motor_drive, want.motor_drive);
        check_field("run_mode", res_if.data.run_mode, want.run_mode);
        check_field("fan_speed", res_if.data.fan_speed, want.fan_speed);
        check_field("minutes_shown", res_if.data.minutes_shown, want.minutes_shown);
        check_field("seconds_shown", res_if.data.seconds_shown, want.seconds_shown);
        check_field("countdown_active", res_if.data.countdown_active,
                    want.countdown_active);
        check_field("tx_valid", res_if.data.tx_valid, want.tx_valid);
        check_field("tx_byte", res_if.data.tx_byte, want.tx_byte);
      end
      rx_wait = draw_wait(rx_burst);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    res_if.ready <= (rx_wait == 0);
  end

  always @(posedge clk) begin
    if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no request moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    ev_if.valid  = 1'b0;
    ev_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    reset_fan_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_commands();
    test_mixed_events(200);
    test_countdowns(250);
    test_pwm_periods(1000);
    repeat (8) @(posedge clk);
    $display("%0d events, %0d results checked, %0d register sets loaded",
             events_sent, results_seen, settings_loaded);
    $display("%0d countdowns ran out, %0d pwm periods completed, %0d mismatches",
             timer_expiries, pwm_wraps, mismatches);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fts_pkg.sv
hw/rtl/fts_if.sv
hw/rtl/fts_front.sv
hw/rtl/fts_queue.sv
hw/rtl/fts_back.sv
hw/rtl/fan_timer_speed_controller.sv
verif/tb_top.sv
